[hdl/nbpw_pkg.sv]
// Shared types, constants and helpers for the nibble blitter pixel writer.
package nbpw_pkg;

  localparam int ROM_AW = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GFX_FLAGS   = 3'd0,
    REG_SIZE_X      = 3'd1,
    REG_SIZE_Y      = 3'd2,
    REG_LAYER_INDEX = 3'd3,
    REG_PAL_LOW     = 3'd4,
    REG_PAL_HIGH    = 3'd5,
    REG_ROM_LAST    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_BYTE  = 1'b1
  } req_t;

  typedef struct packed {
    logic flip_x;
    logic flip_y;
    logic transp;
    logic scr_flip;
  } gfx_ctl_t;

  typedef struct packed {
    logic [9:0] first_color;
    logic [9:0] second_color;
    logic       first_write;
    logic       second_write;
  } pix_pair_t;

  function automatic logic [ROM_AW-1:0] wrap_addr(input logic [ROM_AW-1:0] a,
                                                  input logic [23:0] last);
    return (24'(a) > last) ? '0 : a;
  endfunction

endpackage

[hdl/nbpw_pixel_map.sv]
// Palette lookup, layer tagging and transparency for one pixel pair.
module nbpw_pixel_map (
  input  logic [7:0]          gfx_byte,
  input  nbpw_pkg::gfx_ctl_t  ctl,
  input  logic [1:0]          layer,
  input  logic [63:0]         pal_low,
  input  logic [63:0]         pal_high,
  output nbpw_pkg::pix_pair_t pix
);
  import nbpw_pkg::*;

  logic [3:0] nib1;
  logic [3:0] nib2;
  logic [7:0] pal1;
  logic [7:0] pal2;

  function automatic logic [7:0] pal_lookup(input logic [3:0] idx,
                                            input logic [63:0] lo,
                                            input logic [63:0] hi);
    logic [127:0] pal;
    pal = {hi, lo};
    return pal[idx*8 +: 8];
  endfunction

  always_comb begin
    nib1 = ctl.flip_x ? gfx_byte[7:4] : gfx_byte[3:0];
    nib2 = ctl.flip_x ? gfx_byte[3:0] : gfx_byte[7:4];
    pal1 = pal_lookup(nib1, pal_low, pal_high);
    pal2 = pal_lookup(nib2, pal_low, pal_high);
    pix.first_color  = {layer, pal1};
    pix.second_color = {layer, pal2};
    pix.first_write  = !(ctl.transp && (pal1 == 8'hff));
    pix.second_write = !(ctl.transp && (pal2 == 8'hff));
  end

endmodule

[hdl/nibble_blitter_pixel_writer_top.sv]
// Top level of the nibble blitter pixel writer.
//
// Input channel (in_valid / in_stall): a start transfer (req_type 0) latches
// a blit from the raw X/Y positions and ROM start address and returns one
// result carrying the first fetch address (start+2, wrapped) with all pixel
// fields zero. Each byte transfer (req_type 1) during a blit returns one
// result with two pixels, their row, colors, write enables, the next fetch
// address and blit_done on the last byte. A byte with no blit active is
// dropped. A start during a blit aborts it.
// Configuration port (cfg_wr_en / cfg_index / cfg_data) writes registers;
// the user must do so only while the block is idle, as the block itself
// does not enforce it. Changes apply from the next item.
// Throughput: one item per cycle; the single output register accepts a new
// item whenever it is empty or its result is taken in the same cycle.
// When out_stall is high with a result waiting, in_stall rises and both
// sides hold. Reset (synchronous, rst_n low) clears the registers to their
// defaults (rom_last_address to all ones), ends any blit and empties the
// output register.
module nibble_blitter_pixel_writer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [nbpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nbpw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [9:0]                      in_draw_x_raw,
  input  logic [8:0]                      in_draw_y_raw,
  input  logic [23:0]                     in_rom_start,
  input  logic [7:0]                      in_gfx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [9:0]                      out_first_x,
  output logic [9:0]                      out_second_x,
  output logic [8:0]                      out_row_y,
  output logic [9:0]                      out_first_color,
  output logic [9:0]                      out_second_color,
  output logic                            out_first_write,
  output logic                            out_second_write,
  output logic [23:0]                     out_fetch_address,
  output logic                            out_blit_done
);
  import nbpw_pkg::*;

  logic [7:0]        gfx_flags_r;
  logic [8:0]        size_x_r;
  logic [8:0]        size_y_r;
  logic [1:0]        layer_r;
  logic [63:0]       pal_low_r;
  logic [63:0]       pal_high_r;
  logic [23:0]       rom_last_r;

  logic [10:0]       origin_x_r, origin_x_nxt;
  logic [9:0]        origin_y_r, origin_y_nxt;
  logic [8:0]        col_pos_r, col_pos_nxt;
  logic [8:0]        row_pos_r, row_pos_nxt;
  logic [9:0]        cols_left_r, cols_left_nxt;
  logic [9:0]        rows_left_r, rows_left_nxt;
  logic [ROM_AW-1:0] rom_ptr_r, rom_ptr_nxt;
  logic              active_r, active_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [9:0]        first_x_r, first_x_nxt;
  logic [9:0]        second_x_r, second_x_nxt;
  logic [8:0]        row_y_r, row_y_nxt;
  logic [9:0]        first_color_r, first_color_nxt;
  logic [9:0]        second_color_r, second_color_nxt;
  logic              first_write_r, first_write_nxt;
  logic              second_write_r, second_write_nxt;
  logic [23:0]       fetch_r, fetch_nxt;
  logic              done_r, done_nxt;

  gfx_ctl_t          ctl;
  pix_pair_t         pix;
  logic              in_xfer;
  logic              out_xfer;
  logic              is_start;
  logic              produce;
  logic [8:0]        base_x;
  logic [8:0]        pos_y;
  logic [9:0]        cols_dec;
  logic [9:0]        rows_dec;
  logic [ROM_AW-1:0] ptr_inc;

  assign ctl.flip_x   = gfx_flags_r[0];
  assign ctl.flip_y   = gfx_flags_r[1];
  assign ctl.transp   = gfx_flags_r[4];
  assign ctl.scr_flip = !gfx_flags_r[6];

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign is_start = (req_t'(in_req_type) == REQ_START);
  assign produce  = is_start || active_r;

  nbpw_pixel_map u_pixel_map (
    .gfx_byte (in_gfx_byte),
    .ctl      (ctl),
    .layer    (layer_r),
    .pal_low  (pal_low_r),
    .pal_high (pal_high_r),
    .pix      (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gfx_flags_r <= '0;
      size_x_r    <= '0;
      size_y_r    <= '0;
      layer_r     <= '0;
      pal_low_r   <= '0;
      pal_high_r  <= '0;
      rom_last_r  <= 24'hffffff;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GFX_FLAGS:   gfx_flags_r <= cfg_data[7:0];
        REG_SIZE_X:      size_x_r    <= cfg_data[8:0];
        REG_SIZE_Y:      size_y_r    <= cfg_data[8:0];
        REG_LAYER_INDEX: layer_r     <= cfg_data[1:0];
        REG_PAL_LOW:     pal_low_r   <= cfg_data;
        REG_PAL_HIGH:    pal_high_r  <= cfg_data;
        REG_ROM_LAST:    rom_last_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base_x   = origin_x_r[8:0] + col_pos_r;
    pos_y    = origin_y_r[8:0] + row_pos_r;
    cols_dec = cols_left_r - 10'd1;
    rows_dec = rows_left_r - 10'd1;
    ptr_inc  = wrap_addr(rom_ptr_r + ROM_AW'(1), rom_last_r);
  end

  always_comb begin
    origin_x_nxt     = origin_x_r;
    origin_y_nxt     = origin_y_r;
    col_pos_nxt      = col_pos_r;
    row_pos_nxt      = row_pos_r;
    cols_left_nxt    = cols_left_r;
    rows_left_nxt    = rows_left_r;
    rom_ptr_nxt      = rom_ptr_r;
    active_nxt       = active_r;
    first_x_nxt      = first_x_r;
    second_x_nxt     = second_x_r;
    row_y_nxt        = row_y_r;
    first_color_nxt  = first_color_r;
    second_color_nxt = second_color_r;
    first_write_nxt  = first_write_r;
    second_write_nxt = second_write_r;
    fetch_nxt        = fetch_r;
    done_nxt         = done_r;
    out_valid_nxt    = out_valid_r && !out_xfer;

    if (in_xfer && produce) begin
      out_valid_nxt = 1'b1;
      if (is_start) begin
        origin_x_nxt  = {1'b0, ~in_draw_x_raw} - 11'(size_x_r);
        origin_y_nxt  = {1'b0, ~in_draw_y_raw} - 10'(size_y_r) - 10'd1;
        col_pos_nxt   = ctl.flip_x ? size_x_r : 9'd0;
        row_pos_nxt   = ctl.flip_y ? size_y_r : 9'd0;
        cols_left_nxt = 10'(size_x_r) + 10'd1;
        rows_left_nxt = 10'(size_y_r) + 10'd1;
        rom_ptr_nxt   = wrap_addr(ROM_AW'(in_rom_start) + ROM_AW'(2), rom_last_r);
        active_nxt    = 1'b1;
        first_x_nxt      = '0;
        second_x_nxt     = '0;
        row_y_nxt        = '0;
        first_color_nxt  = '0;
        second_color_nxt = '0;
        first_write_nxt  = 1'b0;
        second_write_nxt = 1'b0;
        fetch_nxt        = 24'(rom_ptr_nxt);
        done_nxt         = 1'b0;
      end else begin
        rom_ptr_nxt   = ptr_inc;
        cols_left_nxt = cols_dec;
        col_pos_nxt   = ctl.flip_x ? col_pos_r - 9'd1 : col_pos_r + 9'd1;
        done_nxt      = 1'b0;
        if (cols_dec == 10'd0) begin
          rows_left_nxt = rows_dec;
          if (rows_dec == 10'd0) begin
            done_nxt   = 1'b1;
            active_nxt = 1'b0;
          end else begin
            row_pos_nxt   = ctl.flip_y ? row_pos_r - 9'd1 : row_pos_r + 9'd1;
            col_pos_nxt   = ctl.flip_x ? size_x_r : 9'd0;
            cols_left_nxt = 10'(size_x_r) + 10'd1;
          end
        end
        first_x_nxt      = ctl.scr_flip ? ~{base_x, 1'b0} : {base_x, 1'b0};
        second_x_nxt     = ctl.scr_flip ? ~{base_x, 1'b1} : {base_x, 1'b1};
        row_y_nxt        = ctl.scr_flip ? ~pos_y : pos_y;
        first_color_nxt  = pix.first_color;
        second_color_nxt = pix.second_color;
        first_write_nxt  = pix.first_write;
        second_write_nxt = pix.second_write;
        fetch_nxt        = 24'(ptr_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      cols_left_r <= '0;
      rows_left_r <= '0;
      rom_ptr_r   <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      origin_x_r  <= origin_x_nxt;
      origin_y_r  <= origin_y_nxt;
      col_pos_r   <= col_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      cols_left_r <= cols_left_nxt;
      rows_left_r <= rows_left_nxt;
      rom_ptr_r   <= rom_ptr_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_x_r      <= first_x_nxt;
    second_x_r     <= second_x_nxt;
    row_y_r        <= row_y_nxt;
    first_color_r  <= first_color_nxt;
    second_color_r <= second_color_nxt;
    first_write_r  <= first_write_nxt;
    second_write_r <= second_write_nxt;
    fetch_r        <= fetch_nxt;
    done_r         <= done_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_first_x       = first_x_r;
  assign out_second_x      = second_x_r;
  assign out_row_y         = row_y_r;
  assign out_first_color   = first_color_r;
  assign out_second_color  = second_color_r;
  assign out_first_write   = first_write_r;
  assign out_second_write  = second_write_r;
  assign out_fetch_address = fetch_r;
  assign out_blit_done     = done_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_end_reports_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(active_r) && $past(rst_n)) |-> (out_valid_r && done_r))
    else $error("blit ended without a done result");

  a_start_result_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_start) |=>
      (out_valid_r && !done_r && !first_write_r && !second_write_r && active_r))
    else $error("start transfer gave a malformed result");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the nibble blitter pixel writer.
module tb;
  import nbpw_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int IDLE_PCT = 38;
  localparam int QUIET_LIMIT = 2000;
  localparam int SQUEEZE_CYCLES = 120;

  typedef struct {
    req_t        kind;
    logic [9:0]  x;
    logic [8:0]  y;
    logic [23:0] rom;
    logic [7:0]  gbyte;
  } gfx_item_t;

  typedef struct {
    logic [9:0]  fx;
    logic [9:0]  sx;
    logic [8:0]  ry;
    logic [9:0]  fc;
    logic [9:0]  sc;
    logic        fw;
    logic        sw;
    logic [23:0] fa;
    logic        done;
  } pix_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [9:0]  in_draw_x_raw = '0;
  logic [8:0]  in_draw_y_raw = '0;
  logic [23:0] in_rom_start = '0;
  logic [7:0]  in_gfx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_first_x;
  logic [9:0]  out_second_x;
  logic [8:0]  out_row_y;
  logic [9:0]  out_first_color;
  logic [9:0]  out_second_color;
  logic        out_first_write;
  logic        out_second_write;
  logic [23:0] out_fetch_address;
  logic        out_blit_done;

  nibble_blitter_pixel_writer_top u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register shadow
  logic [7:0]  flags = '0;
  logic [8:0]  sz_x = '0;
  logic [8:0]  sz_y = '0;
  logic [1:0]  layer = '0;
  logic [63:0] pal_lo = '0;
  logic [63:0] pal_hi = '0;
  logic [23:0] rom_last = 24'hffffff;

  // blit walker state
  logic [10:0] org_x = '0;
  logic [9:0]  org_y = '0;
  logic [8:0]  col_pos = '0;
  logic [8:0]  row_pos = '0;
  logic [9:0]  cols_left = '0;
  logic [9:0]  rows_left = '0;
  logic [23:0] rom_ptr = '0;
  logic        active = 1'b0;

  gfx_item_t gfx_stream[$];
  pix_res_t  pixel_due[$];
  gfx_item_t cur;
  pix_res_t  want;

  int  errors = 0;
  int  fed = 0;
  int  taken_in = 0;
  int  dropped = 0;
  int  checked = 0;
  int  blits_done = 0;
  int  settings = 0;
  int  quiet = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;
  bit  squeeze = 1'b0;
  bit  squeezed = 1'b0;

  function automatic logic [23:0] rom_fold(input logic [23:0] a);
    return (a > rom_last) ? 24'h0 : a;
  endfunction

  function automatic logic [7:0] pal_entry(input logic [3:0] i);
    return i[3] ? pal_hi[8*i[2:0] +: 8] : pal_lo[8*i[2:0] +: 8];
  endfunction

  task automatic rasterize(input gfx_item_t it);
    logic [10:0] base;
    logic [9:0]  dx1, dx2;
    logic [8:0]  dy;
    logic [3:0]  n1, n2;
    logic [7:0]  p1, p2;
    logic        fx, fy, tr, sf;
    pix_res_t    r;
    fx = flags[0];
    fy = flags[1];
    tr = flags[4];
    sf = !flags[6];
    r = '{default: '0};
    if (it.kind == REQ_START) begin
      org_x = {1'b0, ~it.x} - {2'b00, sz_x};
      org_y = {1'b0, ~it.y} - {1'b0, sz_y} - 10'd1;
      col_pos = fx ? sz_x : 9'd0;
      row_pos = fy ? sz_y : 9'd0;
      cols_left = {1'b0, sz_x} + 10'd1;
      rows_left = {1'b0, sz_y} + 10'd1;
      rom_ptr = rom_fold(it.rom + 24'd2);
      active = 1'b1;
      r.fa = rom_ptr;
      pixel_due.push_back(r);
    end else if (!active) begin
      dropped++;
    end else begin
      base = org_x + {2'b00, col_pos};
      dx1 = {base[8:0], 1'b0};
      dx2 = {base[8:0], 1'b1};
      dy = org_y[8:0] + row_pos;
      n1 = fx ? it.gbyte[7:4] : it.gbyte[3:0];
      n2 = fx ? it.gbyte[3:0] : it.gbyte[7:4];
      p1 = pal_entry(n1);
      p2 = pal_entry(n2);
      if (sf) begin
        dx1 = ~dx1;
        dx2 = ~dx2;
        dy = ~dy;
      end
      rom_ptr = rom_fold(rom_ptr + 24'd1);
      cols_left = cols_left - 10'd1;
      col_pos = fx ? col_pos - 9'd1 : col_pos + 9'd1;
      if (cols_left == 10'd0) begin
        rows_left = rows_left - 10'd1;
        if (rows_left == 10'd0) begin
          r.done = 1'b1;
          active = 1'b0;
        end else begin
          row_pos = fy ? row_pos - 9'd1 : row_pos + 9'd1;
          col_pos = fx ? sz_x : 9'd0;
          cols_left = {1'b0, sz_x} + 10'd1;
        end
      end
      r.fx = dx1;
      r.sx = dx2;
      r.ry = dy;
      r.fc = {layer, p1};
      r.sc = {layer, p2};
      r.fw = !(tr && p1 == 8'hff);
      r.sw = !(tr && p2 == 8'hff);
      r.fa = rom_ptr;
      pixel_due.push_back(r);
    end
  endtask

  // sender: present, hold while stalled, advance on transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        rasterize(cur);
        taken_in++;
      end
      if (gfx_stream.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur = gfx_stream.pop_front();
        in_valid <= 1'b1;
        in_req_type <= cur.kind;
        in_draw_x_raw <= cur.x;
        in_draw_y_raw <= cur.y;
        in_rom_start <= cur.rom;
        in_gfx_byte <= cur.gbyte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void cmp(input string f, input logic [23:0] e, input logic [23:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, f, e, a);
    end
  endfunction

  // receiver: check each transfer, stall at random, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, fetch_address %0h", $time, out_fetch_address);
        end else begin
          want = pixel_due.pop_front();
          checked++;
          if (want.done)
            blits_done++;
          cmp("first_x", 24'(want.fx), 24'(out_first_x));
          cmp("second_x", 24'(want.sx), 24'(out_second_x));
          cmp("row_y", 24'(want.ry), 24'(out_row_y));
          cmp("first_color", 24'(want.fc), 24'(out_first_color));
          cmp("second_color", 24'(want.sc), 24'(out_second_color));
          cmp("first_write", 24'(want.fw), 24'(out_first_write));
          cmp("second_write", 24'(want.sw), 24'(out_second_write));
          cmp("fetch_address", want.fa, out_fetch_address);
          cmp("blit_done", 24'(want.done), 24'(out_blit_done));
        end
      end
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet, pixel_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic set_reg(input cfg_reg_t r, input logic [63:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      REG_GFX_FLAGS:   flags = v[7:0];
      REG_SIZE_X:      sz_x = v[8:0];
      REG_SIZE_Y:      sz_y = v[8:0];
      REG_LAYER_INDEX: layer = v[1:0];
      REG_PAL_LOW:     pal_lo = v;
      REG_PAL_HIGH:    pal_hi = v;
      REG_ROM_LAST:    rom_last = v[23:0];
      default:         ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push(input req_t k, input logic [9:0] x, input logic [8:0] y,
                      input logic [23:0] a, input logic [7:0] b, input bit counted);
    gfx_item_t it;
    it.kind = k;
    it.x = x;
    it.y = y;
    it.rom = a;
    it.gbyte = b;
    gfx_stream.push_back(it);
    if (counted)
      fed++;
  endtask

  task automatic push_rand(input req_t k, input bit counted);
    push(k, 10'($urandom), 9'($urandom), 24'($urandom), 8'($urandom), counted);
  endtask

  task automatic drain();
    while (gfx_stream.size() != 0 || in_valid || pixel_due.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic random_setting();
    logic [63:0] lo, hi;
    logic [23:0] last;
    int pick;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 3) == 0) lo[8*i +: 8] = 8'hff;
      if ($urandom_range(0, 3) == 0) hi[8*i +: 8] = 8'hff;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      lo = '0;
      hi = '0;
    end else if (pick == 1) begin
      lo = '1;
      hi = '1;
    end
    pick = $urandom_range(0, 9);
    last = (pick < 6) ? 24'hffffff : (pick < 8) ? 24'($urandom) : 24'($urandom_range(0, 40));
    pick = $urandom_range(0, 9);
    set_reg(REG_GFX_FLAGS, (pick == 0) ? 64'h0 : (pick == 1) ? 64'hff : 64'($urandom_range(0, 255)));
    set_reg(REG_SIZE_X, ($urandom_range(0, 19) == 0) ? 64'h1ff : 64'($urandom_range(0, 6)));
    set_reg(REG_SIZE_Y, ($urandom_range(0, 19) == 0) ? 64'h1ff : 64'($urandom_range(0, 5)));
    set_reg(REG_LAYER_INDEX, 64'($urandom_range(0, 3)));
    set_reg(REG_PAL_LOW, lo);
    set_reg(REG_PAL_HIGH, hi);
    set_reg(REG_ROM_LAST, {40'h0, last});
    settings++;
  endtask

  task automatic random_blits();
    int nb, n, emit;
    logic [23:0] a;
    nb = $urandom_range(2, 8);
    for (int b = 0; b < nb; b++) begin
      a = $urandom_range(0, 1) ? 24'($urandom) : rom_last - 24'($urandom_range(0, 6));
      push(REQ_START, 10'($urandom), 9'($urandom), a, 8'($urandom), 1'b1);
      n = (int'(sz_x) + 1) * (int'(sz_y) + 1);
      emit = n;
      if (n > 64 || $urandom_range(0, 99) < 15)
        emit = $urandom_range(0, (n > 64) ? 64 : n - 1);
      for (int k = 0; k < emit; k++)
        push_rand(REQ_BYTE, 1'b1);
      if (emit == n && $urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 3)) push_rand(REQ_BYTE, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one-byte blits, screen flipped
    push(REQ_BYTE, 10'h3ff, 9'h1ff, 24'hffffff, 8'hff, 1'b0);
    push(REQ_START, 10'h000, 9'h000, 24'h000000, 8'h00, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h00, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h5a, 1'b0);
    push(REQ_START, 10'h3ff, 9'h1ff, 24'hffffff, 8'hff, 1'b1);
    push(REQ_BYTE, 10'h3ff, 9'h1ff, 24'hffffff, 8'hff, 1'b1);
    push(REQ_START, 10'h155, 9'h0aa, 24'haaaaaa, 8'h55, 1'b1);
    push(REQ_START, 10'h2aa, 9'h155, 24'h555555, 8'haa, 1'b1);
    push(REQ_BYTE, 10'h155, 9'h0aa, 24'haaaaaa, 8'ha5, 1'b1);
    drain();
    settings++;

    // both flips, transparency, layer three, address wrap
    set_reg(REG_GFX_FLAGS, 64'hff);
    set_reg(REG_SIZE_X, 64'd1);
    set_reg(REG_SIZE_Y, 64'd1);
    set_reg(REG_LAYER_INDEX, 64'd3);
    set_reg(REG_PAL_LOW, 64'h00ff_1234_ff56_78ff);
    set_reg(REG_PAL_HIGH, '1);
    set_reg(REG_ROM_LAST, 64'h10);
    settings++;
    push(REQ_START, 10'h001, 9'h001, 24'h00000c, 8'h00, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h0f, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'hf0, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h8e, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h71, 1'b1);
    push(REQ_START, 10'h200, 9'h100, 24'h00000f, 8'h00, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h3c, 1'b1);
    drain();

    // change settings with the blit part done
    set_reg(REG_GFX_FLAGS, 64'h12);
    set_reg(REG_SIZE_X, 64'd2);
    set_reg(REG_ROM_LAST, 64'h0);
    settings++;
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'hc3, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h96, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h69, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h00, 1'b1);
    push(REQ_BYTE, 10'h000, 9'h000, 24'h000000, 8'h11, 1'b0);
    drain();

    // widest row run to the end with no idling
    set_reg(REG_GFX_FLAGS, 64'($urandom_range(0, 255)));
    set_reg(REG_SIZE_X, 64'h1ff);
    set_reg(REG_SIZE_Y, 64'h0);
    set_reg(REG_LAYER_INDEX, 64'($urandom_range(0, 3)));
    set_reg(REG_PAL_LOW, {$urandom, $urandom});
    set_reg(REG_ROM_LAST, 64'hffffff);
    settings++;
    calm = 1'b1;
    push_rand(REQ_START, 1'b1);
    repeat (512) push_rand(REQ_BYTE, 1'b1);
    drain();
    calm = 1'b0;

    // tallest blits, cut short
    set_reg(REG_SIZE_Y, 64'h1ff);
    settings++;
    push_rand(REQ_START, 1'b1);
    repeat (40) push_rand(REQ_BYTE, 1'b1);
    drain();
    set_reg(REG_SIZE_X, 64'h0);
    settings++;
    push_rand(REQ_START, 1'b1);
    repeat (40) push_rand(REQ_BYTE, 1'b1);
    drain();

    while (fed < ITEM_TARGET) begin
      random_setting();
      random_blits();
      squeeze = 1'b1;
      drain();
    end

    drain();
    repeat (5) @(posedge clk);
    $display("%0d transfers in (%0d bytes dropped with no blit), %0d results checked",
             taken_in, dropped, checked);
    $display("%0d blits completed across %0d register settings", blits_done, settings);
    if (errors == 0 && pixel_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
